// ===== rtl/gbrd_pkg.sv =====
// Shared constants and widths for the glyph bitmap run-length decoder.
package gbrd_pkg;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned SIDE_W  = 11;
	localparam int unsigned POS_W   = 21;
	localparam int unsigned INDEX_W = 20;
	localparam int unsigned PROD_W  = 2 * SIDE_W;

	localparam logic [CODE_W-1:0] ESCAPE_CODE = 8'h41;
	localparam logic [CODE_W-1:0] RUN_BIAS    = 8'h40;

	// Largest pixel count a glyph can hold.
	localparam logic [POS_W-1:0] TOTAL_CAP = 21'h10_0000;

	localparam logic FMT_ESCAPE = 1'b0;
	localparam logic FMT_BIASED = 1'b1;

endpackage

// ===== rtl/glyph_bitmap_rle_decoder.sv =====
// Top level of the glyph bitmap run-length decoder.
//
// The block takes one compressed code byte per transfer on the input channel
// (in_valid / in_ready) and gives at most one pixel run per byte on the output
// channel (out_valid / out_ready). A run names its pixel value, the linear
// index of its first pixel, its length, whether it was cut at the end of the
// glyph, and whether it fills the last pixel of the glyph. The first byte of
// a glyph carries glyph_start with the glyph's width and height.
// The format register (cfg_write_en / cfg_write_data) picks escape-plus-length
// runs (0) or biased run codes (1); the user must write it only while the
// block idles, which the block does not enforce. An input transfer registers
// the byte with the clamped width times height product in the first stage; the
// second stage then decodes it against the running glyph state and loads the
// output register. Throughput is one byte per cycle unless the receiver
// stalls; the decode state is a loop through the second stage, so every byte
// sees the state left by the byte before it. Bytes that give no run (escapes,
// zero counts, bytes after a glyph is complete) pass through without a result.
// Reset clears both stage valids, the glyph state and sets the format to 1.
// When the receiver stalls, the output register holds its run, both stages
// hold, and in_ready drops once the first stage is occupied.
module glyph_bitmap_rle_decoder
	import gbrd_pkg::*;
#(
	parameter int unsigned MAX_SIDE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic                cfg_write_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CODE_W-1:0]   code_byte,
	input  logic                glyph_start,
	input  logic [SIDE_W-1:0]   glyph_width,
	input  logic [SIDE_W-1:0]   glyph_height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   pixel_value,
	output logic [INDEX_W-1:0]  start_index,
	output logic [CODE_W-1:0]   run_count,
	output logic                run_clipped,
	output logic                glyph_done
);

	// A side can never exceed what the port can carry, so the limit is
	// folded down to the port width at elaboration.
	localparam int unsigned SIDE_MAX_IN = (1 << SIDE_W) - 1;
	localparam int unsigned SIDE_LIM_I  = (MAX_SIDE > SIDE_MAX_IN) ? SIDE_MAX_IN : MAX_SIDE;
	localparam logic [SIDE_W-1:0] SIDE_LIM = SIDE_LIM_I[SIDE_W-1:0];

	// Configuration.
	logic format_version_q;

	// First stage.
	logic                v_s1;
	logic [CODE_W-1:0]   code_s1;
	logic                start_s1;
	logic [POS_W-1:0]    total_s1;

	// Glyph state.
	logic                esc_q;
	logic [CODE_W-1:0]   last_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    total_q;

	// Output register.
	logic                out_valid_q;
	logic [CODE_W-1:0]   pix_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CODE_W-1:0]   cnt_q;
	logic                clip_q;
	logic                done_q;

	logic                advance;
	logic [SIDE_W-1:0]   w_clamp;
	logic [SIDE_W-1:0]   h_clamp;
	logic [PROD_W-1:0]   area;
	logic [POS_W-1:0]    area_sat;

	logic                esc_eff;
	logic [CODE_W-1:0]   last_eff;
	logic [POS_W-1:0]    pos_eff;
	logic [POS_W-1:0]    total_eff;
	logic                active;
	logic                is_run_code;
	logic                is_escape;
	logic                emit;
	logic                literal;
	logic [CODE_W-1:0]   run_len;
	logic [CODE_W-1:0]   value;
	logic [POS_W-1:0]    remain;
	logic                clip;
	logic [CODE_W-1:0]   count;
	logic [POS_W-1:0]    pos_next;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_version_q <= FMT_BIASED;
		end else if (cfg_write_en) begin
			format_version_q <= cfg_write_data;
		end
	end

	// Glyph area: each side saturated, then the product saturated.
	always_comb begin
		w_clamp  = (glyph_width  > SIDE_LIM) ? SIDE_LIM : glyph_width;
		h_clamp  = (glyph_height > SIDE_LIM) ? SIDE_LIM : glyph_height;
		area     = PROD_W'(w_clamp) * PROD_W'(h_clamp);
		area_sat = (area > PROD_W'(TOTAL_CAP)) ? TOTAL_CAP : area[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1  <= code_byte;
			start_s1 <= glyph_start;
			total_s1 <= area_sat;
		end
	end

	// Decode of the byte in the first stage against the glyph state.
	always_comb begin
		esc_eff   = start_s1 ? 1'b0 : esc_q;
		last_eff  = start_s1 ? '0 : last_q;
		pos_eff   = start_s1 ? '0 : pos_q;
		total_eff = start_s1 ? total_s1 : total_q;
		active    = pos_eff < total_eff;

		is_escape   = (format_version_q == FMT_ESCAPE) && (code_s1 == ESCAPE_CODE);
		is_run_code = (format_version_q == FMT_BIASED) && (code_s1 >= ESCAPE_CODE);

		if (esc_eff) begin
			run_len = code_s1;
			value   = last_eff;
			emit    = code_s1 != '0;
			literal = 1'b0;
		end else if (is_run_code) begin
			run_len = code_s1 - RUN_BIAS;
			value   = last_eff;
			emit    = 1'b1;
			literal = 1'b0;
		end else begin
			run_len = CODE_W'(1);
			value   = code_s1;
			emit    = !is_escape;
			literal = !is_escape;
		end

		remain   = total_eff - pos_eff;
		clip     = POS_W'(run_len) > remain;
		count    = clip ? remain[CODE_W-1:0] : run_len;
		pos_next = pos_eff + POS_W'(count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			last_q  <= '0;
			pos_q   <= '0;
			total_q <= '0;
		end else if (v_s1 && advance) begin
			total_q <= total_eff;
			if (active) begin
				esc_q  <= !esc_eff && is_escape;
				last_q <= literal ? code_s1 : last_eff;
				pos_q  <= emit ? pos_next : pos_eff;
			end else begin
				esc_q  <= esc_eff;
				last_q <= last_eff;
				pos_q  <= pos_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1 && active && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1 && active && emit) begin
			pix_q  <= value;
			idx_q  <= pos_eff[INDEX_W-1:0];
			cnt_q  <= count;
			clip_q <= clip;
			done_q <= pos_next >= total_eff;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pix_q;
	assign start_index = idx_q;
	assign run_count   = cnt_q;
	assign run_clipped = clip_q;
	assign glyph_done  = done_q;

	// The position never passes the glyph's pixel total.
	a_pos_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= total_q)
		else $error("pixel position beyond glyph total");

	// A delivered run always covers at least one pixel.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cnt_q != '0))
		else $error("empty run delivered");

	// A clipped run always ends the glyph.
	a_clip_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clip_q) |-> done_q)
		else $error("clipped run without glyph completion");

	// A finished run is held while the receiver stalls.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(idx_q)))
		else $error("stalled run changed");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the glyph bitmap run-length decoder.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gbrd_pkg::*;

	localparam int unsigned SIDE_MAX   = 1024;
	// Cycles allowed after the last run for the two-stage pipeline to go quiet.
	localparam int unsigned SETTLE_CYC = 8;
	// Percentage of cycles in which a side idles when it is allowed to.
	localparam int unsigned IDLE_PCT   = 23;

	// One decoded pixel run, as it appears on the output channel.
	typedef struct packed {
		logic [CODE_W-1:0]  value;
		logic [INDEX_W-1:0] index;
		logic [CODE_W-1:0]  count;
		logic               clipped;
		logic               done;
	} pixel_run_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_write_en   = 1'b0;
	logic                cfg_write_data = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [CODE_W-1:0]   code_byte      = '0;
	logic                glyph_start    = 1'b0;
	logic [SIDE_W-1:0]   glyph_width    = '0;
	logic [SIDE_W-1:0]   glyph_height   = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [CODE_W-1:0]   pixel_value;
	logic [INDEX_W-1:0]  start_index;
	logic [CODE_W-1:0]   run_count;
	logic                run_clipped;
	logic                glyph_done;

	glyph_bitmap_rle_decoder #(
		.MAX_SIDE(SIDE_MAX)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_byte      (code_byte),
		.glyph_start    (glyph_start),
		.glyph_width    (glyph_width),
		.glyph_height   (glyph_height),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_value    (pixel_value),
		.start_index    (start_index),
		.run_count      (run_count),
		.run_clipped    (run_clipped),
		.glyph_done     (glyph_done)
	);

	// The clock runs with a 10 ns period, low for the first half period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the testbench predicts it. It is updated at the
	// clock edge where each input transfer or register write happens.
	logic              fmt_sel;
	logic              esc_pending;
	logic [CODE_W-1:0] last_px;
	logic [POS_W-1:0]  px_pos;
	logic [POS_W-1:0]  px_total;

	// Runs the block still owes us, oldest first.
	pixel_run_t pending_runs[$];

	// When set, neither side idles, which gives one long stretch of
	// back-to-back transfers.
	bit steady_flow = 1'b0;

	int unsigned mismatches    = 0;
	int unsigned bytes_sent    = 0;
	int unsigned bytes_decoded = 0;
	int unsigned runs_checked  = 0;
	int unsigned clipped_runs  = 0;
	int unsigned glyphs_filled = 0;
	int unsigned fmt_writes    = 0;

	// Every failure goes through here: one line, one count. Printing stops
	// after a while so a broken block cannot flood the log.
	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t ns] ERROR: %s", $realtime, msg);
	endtask

	// Works out what the block does with one accepted byte. It returns 1 and
	// fills run when the byte yields a pixel run, and 0 when it yields none.
	function automatic bit decode_byte(input logic [CODE_W-1:0] code, input logic start,
		input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h, output pixel_run_t run);
		int unsigned       ws;
		int unsigned       hs;
		int unsigned       prod;
		int unsigned       remain;
		int unsigned       len;
		logic [CODE_W-1:0] value;
		run = '0;
		// A glyph start samples the size, with each side and then the product
		// saturated, and clears the per-glyph state before the byte decodes.
		if (start) begin
			ws = (32'(w) > SIDE_MAX) ? SIDE_MAX : 32'(w);
			hs = (32'(h) > SIDE_MAX) ? SIDE_MAX : 32'(h);
			prod = ws * hs;
			if (prod > 32'(TOTAL_CAP))
				prod = 32'(TOTAL_CAP);
			px_total    = prod[POS_W-1:0];
			px_pos      = '0;
			last_px     = '0;
			esc_pending = 1'b0;
		end
		// A zero-size or already filled glyph ignores the byte entirely.
		if (px_pos >= px_total)
			return 1'b0;
		bytes_decoded++;
		if (esc_pending) begin
			// The byte after an escape is a count in either format.
			esc_pending = 1'b0;
			if (code == '0)
				return 1'b0;
			len   = 32'(code);
			value = last_px;
		end else if (fmt_sel == FMT_ESCAPE && code == ESCAPE_CODE) begin
			esc_pending = 1'b1;
			return 1'b0;
		end else if (fmt_sel == FMT_BIASED && code >= ESCAPE_CODE) begin
			len   = 32'(code - RUN_BIAS);
			value = last_px;
		end else begin
			last_px = code;
			len     = 1;
			value   = code;
		end
		// A run that would overrun the glyph is cut to the pixels left.
		remain      = 32'(px_total - px_pos);
		run.value   = value;
		run.index   = px_pos[INDEX_W-1:0];
		run.clipped = (len > remain);
		if (len > remain)
			len = remain;
		run.count = len[CODE_W-1:0];
		px_pos    = px_pos + len[POS_W-1:0];
		run.done  = (px_pos >= px_total);
		return 1'b1;
	endfunction

	// Sends one code byte. The task is entered at a falling edge; it may
	// idle at random first, then holds the transfer until it is
	// accepted, predicts its run and returns at the next falling edge with
	// valid still high, so back-to-back bytes never drop valid.
	task automatic send_byte(input logic [CODE_W-1:0] code, input logic start,
		input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
		pixel_run_t run;
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		code_byte    = code;
		glyph_start  = start;
		glyph_width  = w;
		glyph_height = h;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
		if (decode_byte(code, start, w, h, run))
			pending_runs.push_back(run);
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted run has been checked,
	// then lets the pipeline settle so that it finishes bytes that yield no run.
	task automatic wait_for_runs();
		in_valid = 1'b0;
		while (pending_runs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Writes the format register. Only called while the block is idle.
	task automatic write_format(input logic value);
		cfg_write_en   = 1'b1;
		cfg_write_data = value;
		@(posedge clk);
		fmt_sel = value;
		fmt_writes++;
		@(negedge clk);
		cfg_write_en   = 1'b0;
		cfg_write_data = 1'($urandom_range(1));
	endtask

	// The receiver is ready most of the time and stalls at random.
	always @(negedge clk)
		out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

	// Every output transfer is compared field by field with the oldest
	// predicted run.
	always @(posedge clk) begin
		pixel_run_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_runs.size() == 0) begin
				report_error($sformatf("run with no prediction waiting: value 0x%0h index %0d count %0d",
					pixel_value, start_index, run_count));
			end else begin
				want = pending_runs.pop_front();
				runs_checked++;
				if (want.clipped)
					clipped_runs++;
				if (want.done)
					glyphs_filled++;
				if (pixel_value !== want.value)
					report_error($sformatf("pixel_value got 0x%0h expected 0x%0h",
						pixel_value, want.value));
				if (start_index !== want.index)
					report_error($sformatf("start_index got %0d expected %0d",
						start_index, want.index));
				if (run_count !== want.count)
					report_error($sformatf("run_count got %0d expected %0d",
						run_count, want.count));
				if (run_clipped !== want.clipped)
					report_error($sformatf("run_clipped got %0b expected %0b",
						run_clipped, want.clipped));
				if (glyph_done !== want.done)
					report_error($sformatf("glyph_done got %0b expected %0b",
						glyph_done, want.done));
			end
		end
	end

	// Biased run codes straight out of reset: a run at the very start of a
	// glyph repeats a zero pixel, the smallest and largest run codes, and a
	// run that overruns the glyph and gets cut.
	task automatic test_reset_format();
		send_byte(8'h45, 1'b1, 11'd4, 11'd4);
		send_byte(8'h00, 1'b0, 11'd0, 11'd0);
		send_byte(ESCAPE_CODE, 1'b0, 11'd0, 11'd0);
		send_byte(8'hFF, 1'b0, 11'd0, 11'd0);
		// The glyph is full now, so this byte is dropped without a run.
		send_byte(8'h09, 1'b0, 11'd0, 11'd0);
		wait_for_runs();
	endtask

	// Escape format: an escape as the first byte of a glyph, a zero count,
	// literals at the top and the middle of the byte range, and a long run that is cut.
	task automatic test_escape_format();
		write_format(FMT_ESCAPE);
		send_byte(ESCAPE_CODE, 1'b1, 11'd10, 11'd10);
		send_byte(8'd3, 1'b0, 11'd0, 11'd0);
		send_byte(8'hFF, 1'b0, 11'd0, 11'd0);
		send_byte(ESCAPE_CODE, 1'b0, 11'd0, 11'd0);
		send_byte(8'd0, 1'b0, 11'd0, 11'd0);
		send_byte(8'h80, 1'b0, 11'd0, 11'd0);
		send_byte(ESCAPE_CODE, 1'b0, 11'd0, 11'd0);
		send_byte(8'hFF, 1'b0, 11'd0, 11'd0);
		wait_for_runs();
	endtask

	// Glyph sizes at the extremes: zero width, zero height, and the largest
	// glyph, whose side product reaches the pixel cap exactly.
	task automatic test_glyph_sizes();
		send_byte(8'h21, 1'b1, 11'd0, 11'd5);
		send_byte(8'h22, 1'b0, 11'd7, 11'd7);
		send_byte(8'h23, 1'b1, 11'd1024, 11'd0);
		send_byte(8'h24, 1'b1, 11'd1024, 11'd1024);
		send_byte(ESCAPE_CODE, 1'b0, 11'd0, 11'd0);
		send_byte(8'hFE, 1'b0, 11'd0, 11'd0);
		wait_for_runs();
	endtask

	// An escape left pending across a format change still takes the next
	// byte as a plain count, not as a biased run code.
	task automatic test_pending_escape();
		send_byte(8'h12, 1'b1, 11'd20, 11'd20);
		send_byte(ESCAPE_CODE, 1'b0, 11'd0, 11'd0);
		wait_for_runs();
		write_format(FMT_BIASED);
		send_byte(8'h50, 1'b0, 11'd0, 11'd0);
		send_byte(8'h41, 1'b0, 11'd0, 11'd0);
		wait_for_runs();
	endtask

	// Picks the next code byte of a glyph. Most bytes are literals or runs
	// that suit the current format or, after an escape, counts; the rest are arbitrary bytes.
	function automatic logic [CODE_W-1:0] pick_code();
		int unsigned r;
		r = $urandom_range(99);
		if (esc_pending) begin
			if (r < 10)
				return 8'd0;
			if (r < 20)
				return CODE_W'($urandom_range(255));
			return CODE_W'($urandom_range(1, 24));
		end
		if (r < 50)
			return CODE_W'($urandom_range(0, 8'h40));
		if (r < 80) begin
			if (fmt_sel == FMT_ESCAPE)
				return ESCAPE_CODE;
			if (r < 72)
				return CODE_W'($urandom_range(8'h41, 8'h4C));
			return CODE_W'($urandom_range(8'h41, 8'hFF));
		end
		return CODE_W'($urandom_range(255));
	endfunction

	// Random glyphs in one format until about goal bytes have been decoded.
	// Most glyphs are small so they get filled; a few are large and are
	// abandoned part way by the next glyph start.
	task automatic test_random_glyphs(input logic fmt_value, input int unsigned goal);
		int unsigned       first_count;
		int unsigned       r;
		int unsigned       max_bytes;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		bit                first;
		write_format(fmt_value);
		first_count = bytes_decoded;
		while (bytes_decoded - first_count < goal) begin
			r = $urandom_range(99);
			if (r < 5) begin
				w = $urandom_range(1) ? 11'd0 : SIDE_W'($urandom_range(SIDE_MAX));
				h = (w == '0) ? SIDE_W'($urandom_range(SIDE_MAX)) : 11'd0;
			end else if (r < 70) begin
				w = SIDE_W'($urandom_range(1, 12));
				h = SIDE_W'($urandom_range(1, 12));
			end else if (r < 85) begin
				w = SIDE_W'($urandom_range(1, 64));
				h = SIDE_W'($urandom_range(1, 8));
			end else if (r < 95) begin
				w = $urandom_range(1) ? 11'd1024 : SIDE_W'($urandom_range(SIDE_MAX));
				h = SIDE_W'($urandom_range(1, 3));
			end else begin
				w = SIDE_W'($urandom_range(SIDE_MAX));
				h = SIDE_W'($urandom_range(SIDE_MAX));
			end
			max_bytes = $urandom_range(4, 40);
			first = 1'b1;
			for (int unsigned k = 0; k < max_bytes; k++) begin
				// Once the glyph is full, sometimes send a little junk after it.
				if (!first && px_pos >= px_total) begin
					if ($urandom_range(3) == 0)
						repeat ($urandom_range(1, 3))
							send_byte(CODE_W'($urandom_range(255)), 1'b0,
								SIDE_W'($urandom_range(2047)),
								SIDE_W'($urandom_range(2047)));
					break;
				end
				if (first)
					send_byte(pick_code(), 1'b1, w, h);
				else
					send_byte(pick_code(), 1'b0, SIDE_W'($urandom_range(2047)),
						SIDE_W'($urandom_range(2047)));
				first = 1'b0;
			end
		end
		wait_for_runs();
	endtask

	initial begin
		fmt_sel     = FMT_BIASED;
		esc_pending = 1'b0;
		last_px     = '0;
		px_pos      = '0;
		px_total    = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_format();
		test_escape_format();
		test_glyph_sizes();
		test_pending_escape();

		test_random_glyphs(FMT_ESCAPE, 320);
		test_random_glyphs(FMT_BIASED, 320);
		// One long stretch with neither side idling.
		steady_flow = 1'b1;
		test_random_glyphs(FMT_ESCAPE, 320);
		steady_flow = 1'b0;
		test_random_glyphs(FMT_BIASED, 320);

		wait_for_runs();
		repeat (10) @(negedge clk);
		if (pending_runs.size() != 0)
			report_error($sformatf("%0d predicted runs never arrived", pending_runs.size()));

		$display("Sent %0d code bytes (%0d decoded) over %0d format writes.",
			bytes_sent, bytes_decoded, fmt_writes);
		$display("Checked %0d runs: %0d clipped, %0d completed glyphs, %0d errors.",
			runs_checked, clipped_runs, glyphs_filled, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
